FILE: src/rtd_pkg.sv
`timescale 1ns / 1ps
// rtd_pkg: shared constants, types and memory request and response structs
// for the ROLZ token decoder. No dependencies; imported by all but rtd_checker.

package rtd_pkg;

    localparam int HIST_BITS     = 12;            // history window, log2
    localparam int HIST_DEPTH    = 1 << HIST_BITS;
    localparam int LEN_USED_BITS = 6;             // used bits of match_length
    localparam int HOP_USED_BITS = 4;             // used bits of chain_steps
    localparam int SYMBOLS       = 256;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int STEPS_W    = 4;
    localparam int S_TDATA_W  = 24;               // 18 payload bits, byte padded

    localparam logic [LEN_W-1:0]   COUNT_MASK = LEN_W'((1 << LEN_USED_BITS) - 1);
    localparam logic [STEPS_W-1:0] STEP_MASK  = STEPS_W'((1 << HOP_USED_BITS) - 1);

    typedef logic [HIST_BITS-1:0] hist_addr_t;
    typedef logic [BYTE_W-1:0]    sym_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOP,
        S_COPY,
        S_PUSH,
        S_BAD
    } state_t;

    // history memory: chain link and byte share one entry per position
    typedef struct packed {
        logic       rd_en;
        hist_addr_t rd_addr;
        logic       wr_en;
        hist_addr_t wr_addr;
        hist_addr_t wr_link;
        sym_t       wr_byte;
    } hist_req_t;

    typedef struct packed {
        hist_addr_t link;
        sym_t       data;
    } hist_rsp_t;

    // last-seen table, one entry per byte value
    typedef struct packed {
        logic       rd_en;
        sym_t       rd_sym;
        logic       wr_en;
        sym_t       wr_sym;
        hist_addr_t wr_pos;
    } ls_req_t;

    typedef struct packed {
        logic       valid;
        hist_addr_t pos;
    } ls_rsp_t;

endpackage

FILE: src/rolz_token_decoder.sv
`timescale 1ns / 1ps
// rolz_token_decoder: top level of the order-1 ROLZ token decoder.
// Depends on rtd_pkg, rtd_seq, rtd_hist_mem and rtd_last_seen.
//
// - Slave stream takes one token per word. tuser = is_pair; tdata holds
//   literal, match_length and chain_steps. Master stream gives one decoded
//   byte per word; tlast marks the final byte of a token, tuser flags a
//   match that arrived before any byte was produced (data is zero then).
// - A literal goes through the last-seen table read, then the write-back
//   that also loads the output register.
// - A match first walks the chain (one history memory read per hop, the
//   next address comes straight from the read data), then handles each
//   copied byte by a history read, a last-seen read and a write-back.
//   A zero-length match is retired in the cycle it is taken.
// - One token is in work at a time; s_tready is high only between tokens.
//   A finished word waits in the output register while the next token is
//   taken in.
// - m_tready low holds the output word and stalls the sequencer at its next
//   write-back; nothing is dropped.
// - Reset clears the position counter, the fill flag and the last-seen valid
//   bits at once; no clearing pass is needed, links to not-yet-written
//   history slots read as zero via the fill count.

module rolz_token_decoder
    import rtd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // literal[7:0], match_length[13:8],
                                            // chain_steps[17:14], zero pad
    input  logic                 s_tuser,   // is_pair
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,   // data_byte[7:0]
    output logic                 m_tlast,
    output logic                 m_tuser    // bad_token
);

    hist_req_t hist_req;
    hist_rsp_t hist_rsp;
    ls_req_t   ls_req;
    ls_rsp_t   ls_rsp;

    rtd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .hist_req (hist_req),
        .hist_rsp (hist_rsp),
        .ls_req   (ls_req),
        .ls_rsp   (ls_rsp)
    );

    // chain links and history bytes, indexed by output position
    rtd_hist_mem u_hist (
        .clk (clk),
        .req (hist_req),
        .rsp (hist_rsp)
    );

    // newest position of each byte value
    rtd_last_seen u_last_seen (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ls_req),
        .rsp   (ls_rsp)
    );

endmodule

FILE: src/rtd_hist_mem.sv
`timescale 1ns / 1ps
// rtd_hist_mem: history window memory, one entry per output position holding
// the chain link and the byte. Depends on rtd_pkg.

module rtd_hist_mem
    import rtd_pkg::*;
(
    input  logic      clk,
    input  hist_req_t req,
    output hist_rsp_t rsp
);

    hist_rsp_t mem [HIST_DEPTH];
    hist_rsp_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= '{link: req.wr_link, data: req.wr_byte};
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rsp = rdata_reg;

endmodule

FILE: src/rtd_last_seen.sv
`timescale 1ns / 1ps
// rtd_last_seen: newest position of each byte value, with per-entry valid
// bits that flag unwritten entries. Depends on rtd_pkg.

module rtd_last_seen
    import rtd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ls_req_t req,
    output ls_rsp_t rsp
);

    hist_addr_t         mem [SYMBOLS];
    logic [SYMBOLS-1:0] valid_reg;
    hist_addr_t         pos_rd_reg;
    logic               valid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_sym] <= req.wr_pos;
        end
        if (req.rd_en)
        begin
            pos_rd_reg <= mem[req.rd_sym];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_sym] <= 1'b1;
            end
            if (req.rd_en)
            begin
                valid_rd_reg <= valid_reg[req.rd_sym];
            end
        end
    end

    assign rsp = '{valid: valid_rd_reg, pos: pos_rd_reg};

endmodule

FILE: src/rtd_seq.sv
`timescale 1ns / 1ps
// rtd_seq: token sequencer. Walks the chain, copies bytes, updates both
// memories and holds the output word register. Depends on rtd_pkg.

module rtd_seq
    import rtd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser,
    output hist_req_t            hist_req,
    input  hist_rsp_t            hist_rsp,
    output ls_req_t              ls_req,
    input  ls_rsp_t              ls_rsp
);

    state_t              state_reg, state_next;
    logic [31:0]         pos_reg, pos_next;
    logic                full_reg, full_next;
    logic [STEPS_W-1:0]  hops_reg, hops_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    hist_addr_t          src_reg, src_next;
    sym_t                byte_reg, byte_next;
    logic                fwd_reg, fwd_next;
    logic                lvalid_reg, lvalid_next;
    logic                m_tvalid_reg, m_tvalid_next;
    sym_t                m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;
    logic                m_tuser_reg, m_tuser_next;

    logic                accept;
    logic                out_free;
    logic                in_pair;
    sym_t                in_lit;
    logic [LEN_W-1:0]    in_len;
    logic [STEPS_W-1:0]  in_steps;
    hist_addr_t          slot;
    hist_addr_t          first_addr;
    hist_addr_t          hop_pos;
    hist_addr_t          src_inc;
    sym_t                copy_byte;
    hist_addr_t          ls_link;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign in_pair    = s_tuser;
    assign in_lit     = s_tdata[7:0];
    assign in_len     = s_tdata[13:8] & COUNT_MASK;
    assign in_steps   = s_tdata[17:14] & STEP_MASK;
    assign slot       = pos_reg[HIST_BITS-1:0];
    assign first_addr = hist_addr_t'(slot - 1'b1);
    // links to slots not yet written read as zero
    assign hop_pos    = lvalid_reg ? hist_rsp.link : '0;
    assign src_inc    = hist_addr_t'(src_reg + 1'b1);
    assign copy_byte  = fwd_reg ? byte_reg : hist_rsp.data;
    assign ls_link    = ls_rsp.valid ? ls_rsp.pos : '0;

    function automatic logic chain_ok(input hist_addr_t a, input logic full,
                                      input hist_addr_t fill);
        return full || (a < fill);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (!in_pair)
                        state_next = S_PUSH;
                    else if (pos_reg == 32'd0)
                        state_next = S_BAD;
                    else if (in_len == '0)
                        state_next = S_IDLE;
                    else
                        state_next = S_HOP;
                end
            end
            S_HOP:
            begin
                if (hops_reg == '0)
                    state_next = S_COPY;
            end
            S_COPY:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (out_free)
                    state_next = (cnt_reg == LEN_W'(1)) ? S_IDLE : S_COPY;
            end
            S_BAD:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pos_next      = pos_reg;
        full_next     = full_reg;
        hops_next     = hops_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        byte_next     = byte_reg;
        fwd_next      = fwd_reg;
        lvalid_next   = lvalid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        hist_req      = '0;
        ls_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_pair)
                    begin
                        ls_req.rd_en  = 1'b1;
                        ls_req.rd_sym = in_lit;
                        byte_next     = in_lit;
                        cnt_next      = LEN_W'(1);
                    end
                    else if ((pos_reg != 32'd0) && (in_len != '0))
                    begin
                        // first hop starts at the previous output byte
                        hist_req.rd_en   = 1'b1;
                        hist_req.rd_addr = first_addr;
                        lvalid_next      = chain_ok(first_addr, full_reg, slot);
                        hops_next        = in_steps;
                        cnt_next         = in_len;
                    end
                end
            end
            S_HOP:
            begin
                hist_req.rd_en = 1'b1;
                if (hops_reg == '0)
                begin
                    hist_req.rd_addr = hist_addr_t'(hop_pos + 1'b1);
                    src_next         = hist_addr_t'(hop_pos + 1'b1);
                    fwd_next         = 1'b0;
                end
                else
                begin
                    hist_req.rd_addr = hop_pos;
                    lvalid_next      = chain_ok(hop_pos, full_reg, slot);
                    hops_next        = hops_reg - 1'b1;
                end
            end
            S_COPY:
            begin
                byte_next     = copy_byte;
                ls_req.rd_en  = 1'b1;
                ls_req.rd_sym = copy_byte;
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    hist_req.wr_en   = 1'b1;
                    hist_req.wr_addr = slot;
                    hist_req.wr_link = ls_link;
                    hist_req.wr_byte = byte_reg;
                    ls_req.wr_en     = 1'b1;
                    ls_req.wr_sym    = byte_reg;
                    ls_req.wr_pos    = slot;
                    pos_next         = pos_reg + 32'd1;
                    if (&slot)
                        full_next = 1'b1;
                    m_tvalid_next    = 1'b1;
                    m_tdata_next     = byte_reg;
                    m_tlast_next     = (cnt_reg == LEN_W'(1));
                    m_tuser_next     = 1'b0;
                    cnt_next         = cnt_reg - 1'b1;
                    if (cnt_reg != LEN_W'(1))
                    begin
                        // next source may be the slot written this cycle
                        hist_req.rd_en   = 1'b1;
                        hist_req.rd_addr = src_inc;
                        src_next         = src_inc;
                        fwd_next         = (src_inc == slot);
                    end
                end
            end
            S_BAD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = 1'b1;
                end
            end
            default:
            begin
                hist_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            full_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            full_reg     <= full_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hops_reg    <= hops_next;
        cnt_reg     <= cnt_next;
        src_reg     <= src_next;
        byte_reg    <= byte_next;
        fwd_reg     <= fwd_next;
        lvalid_reg  <= lvalid_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: src/rtd_checker.sv
`timescale 1ns / 1ps
// rtd_checker: port-level assertions for rolz_token_decoder, attached by bind.
// Depends on the top level's port list only.

module rtd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // bad token word is a single zero word closing its token
    a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("bad token word malformed");

    // mid-token output means the sequencer is still busy
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("token taken while a match copy is in progress");

    // a literal always occupies the sequencer for its write-back cycle
    a_lit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("ready right after a literal was taken");

endmodule

bind rolz_token_decoder rtd_checker u_rtd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
